// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property check on the rising clock edge, switched off while reset is high.
`define SPWM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define SPWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/spwm_pkg.sv =====
`default_nettype none

package spwm_pkg;

   localparam int VOLT_W     = 16;
   localparam int BUS_W      = 15;
   localparam int SPEED_W    = 20;
   localparam int FREQ_W     = 20;
   localparam int DUTY_W     = 16;
   localparam int MOD_W      = 15;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 20;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;

   // Pipeline shape: four front stages, one divider step per stage, one output stage.
   localparam int FRONT_STAGES = 4;
   localparam int DIV_Q_W      = 20;
   localparam int LATENCY      = FRONT_STAGES + DIV_Q_W + 1;

   localparam int CAR_NUM_W  = 40;
   localparam int MAG_W      = 32;
   localparam int DUTY_NUM_W = 49;
   localparam int LANES      = 3;

   localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
   localparam logic [16:0] HALF_SQRT3_Q16 = 17'd56756;
   localparam logic [15:0] DUTY_HALF      = 16'd32768;
   localparam logic [15:0] DUTY_MAX       = 16'd65535;
   localparam logic [14:0] BUS_MIN        = 15'd16;
   localparam logic [31:0] TINY_MAG       = 32'd10;

   localparam logic [14:0] MAX_MOD_RESET       = 15'd16384;
   localparam logic [19:0] BAND_START_RESET    = 20'd0;
   localparam logic [19:0] BAND_END_RESET      = 20'd0;
   localparam logic [19:0] CARRIER_START_RESET = 20'd16000;
   localparam logic [19:0] CARRIER_END_RESET   = 20'd16000;

   typedef enum logic [2:0] {
      REG_MAX_MOD       = 3'd0,
      REG_BAND_START    = 3'd1,
      REG_BAND_END      = 3'd2,
      REG_CARRIER_START = 3'd3,
      REG_CARRIER_END   = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      CAR_START = 2'd0,
      CAR_END   = 2'd1,
      CAR_RAMP  = 2'd2
   } car_mode_type;

   typedef struct packed {
      logic [14:0] max_mod_index;
      logic [19:0] band_start_freq;
      logic [19:0] band_end_freq;
      logic [19:0] carrier_start_freq;
      logic [19:0] carrier_end_freq;
   } cfg_type;

   typedef struct packed {
      logic low_bus;
      logic sat;
      logic neg;
   } duty_tag_type;

endpackage

`default_nettype wire

// ===== rtl/spwm_duty_and_carrier_ramp.sv =====
`default_nettype none
`include "assert_macros.svh"

// Channel | Direction | Word layout (low bit first)
// req     | in        | volt_alpha[15:0] volt_beta[31:16] bus_voltage[46:32] elec_speed[66:47]
// rsp     | out       | carrier_freq[19:0] duty_u[35:20] duty_v[51:36] duty_w[67:52]
// csr     | in        | csr_index selects the register, csr_data carries the value
//
// One word is accepted per cycle unless a stalled output has filled every stage behind it.
// Each word passes four front stages, twenty restoring divider steps and the output register.
// Each stage holds its own valid bit and loads whenever it is empty or its word moves on,
// so a stalled output still lets words advance into the empty stages behind it.
// Reset, synchronous and active high, empties the pipeline and loads the register defaults.

module spwm_duty_and_carrier_ramp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // volt_alpha, volt_beta, bus_voltage, elec_speed, zero fill
   input  logic [spwm_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // carrier_freq, duty_u, duty_v, duty_w, zero fill
   output logic [spwm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spwm_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [spwm_pkg::CSR_DATA_W-1:0]     csr_data
);

   import spwm_pkg::*;

   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;
   logic [LATENCY-1:0]      valid_ff;
   logic [LATENCY-1:0]      valid_in;
   logic [LATENCY-1:0]      stage_en;

   logic signed [VOLT_W-1:0]  req_volt_alpha;
   logic signed [VOLT_W-1:0]  req_volt_beta;
   logic [BUS_W-1:0]          req_bus_voltage;
   logic signed [SPEED_W-1:0] req_elec_speed;

   logic [CAR_NUM_W-1:0]    car_num;
   logic [FREQ_W-1:0]       car_den;
   car_mode_type            car_mode;
   logic [DIV_Q_W-1:0]      car_quot;
   logic [1:0]              car_tag;
   car_mode_type            car_mode_out;

   logic [DUTY_NUM_W-1:0]   duty_num  [LANES];
   logic [MAG_W-1:0]        duty_den;
   duty_tag_type            duty_tag  [LANES];
   logic [DIV_Q_W-1:0]      duty_quot [LANES];
   duty_tag_type            duty_tag_out [LANES];

   logic [FREQ_W-1:0]       carrier_in;
   logic [DUTY_W-1:0]       duty_in   [LANES];
   logic [RSP_DATA_W-1:0]   rsp_data_ff;

   assign req_volt_alpha  = req_tdata[15:0];
   assign req_volt_beta   = req_tdata[31:16];
   assign req_bus_voltage = req_tdata[46:32];
   assign req_elec_speed  = req_tdata[66:47];

   // Register file.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_MAX_MOD:       cfg_in.max_mod_index      = csr_data[MOD_W-1:0];
            REG_BAND_START:    cfg_in.band_start_freq    = csr_data;
            REG_BAND_END:      cfg_in.band_end_freq      = csr_data;
            REG_CARRIER_START: cfg_in.carrier_start_freq = csr_data;
            REG_CARRIER_END:   cfg_in.carrier_end_freq   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{max_mod_index:      MAX_MOD_RESET,
                     band_start_freq:    BAND_START_RESET,
                     band_end_freq:      BAND_END_RESET,
                     carrier_start_freq: CARRIER_START_RESET,
                     carrier_end_freq:   CARRIER_END_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A stage loads when it is empty or when the stage after it loads.
   assign stage_en[LATENCY-1] = !valid_ff[LATENCY-1] || rsp_tready;
   for (genvar k = 0; k < LATENCY - 1; k++) begin : g_en
      assign stage_en[k] = !valid_ff[k] || stage_en[k+1];
   end

   assign valid_in = ({valid_ff[LATENCY-2:0], req_tvalid} & stage_en) | (valid_ff & ~stage_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_en[0];

   spwm_carrier u_carrier (
      .clock      (clock),
      .stage_en   (stage_en[FRONT_STAGES-1:0]),
      .cfg        (cfg_ff),
      .elec_speed (req_elec_speed),
      .div_num    (car_num),
      .div_den    (car_den),
      .mode       (car_mode)
   );

   spwm_div #(
      .NUM_W (CAR_NUM_W),
      .DEN_W (FREQ_W),
      .Q_W   (DIV_Q_W),
      .SB_W  (2)
   ) u_car_div (
      .clock    (clock),
      .stage_en (stage_en[FRONT_STAGES +: DIV_Q_W]),
      .in_num   (car_num),
      .in_den   (car_den),
      .in_tag   (car_mode),
      .quot     (car_quot),
      .out_tag  (car_tag)
   );

   assign car_mode_out = car_mode_type'(car_tag);

   spwm_duty u_duty (
      .clock         (clock),
      .stage_en      (stage_en[FRONT_STAGES-1:0]),
      .max_mod_index (cfg_ff.max_mod_index),
      .volt_alpha    (req_volt_alpha),
      .volt_beta     (req_volt_beta),
      .bus_voltage   (req_bus_voltage),
      .div_num       (duty_num),
      .div_den       (duty_den),
      .tag           (duty_tag)
   );

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      logic [$bits(duty_tag_type)-1:0] tag_bits;

      spwm_div #(
         .NUM_W (DUTY_NUM_W),
         .DEN_W (MAG_W),
         .Q_W   (DIV_Q_W),
         .SB_W  ($bits(duty_tag_type))
      ) u_duty_div (
         .clock    (clock),
         .stage_en (stage_en[FRONT_STAGES +: DIV_Q_W]),
         .in_num   (duty_num[i]),
         .in_den   (duty_den),
         .in_tag   (duty_tag[i]),
         .quot     (duty_quot[i]),
         .out_tag  (tag_bits)
      );

      assign duty_tag_out[i] = duty_tag_type'(tag_bits);

      // An offset of half the bus or more pins the duty to a rail.
      always_comb begin
         if (duty_tag_out[i].low_bus) begin
            duty_in[i] = DUTY_HALF;
         end else if (duty_tag_out[i].sat) begin
            duty_in[i] = duty_tag_out[i].neg ? '0 : DUTY_MAX;
         end else if (duty_tag_out[i].neg) begin
            duty_in[i] = DUTY_HALF - duty_quot[i][DUTY_W-1:0];
         end else begin
            duty_in[i] = DUTY_HALF + duty_quot[i][DUTY_W-1:0];
         end
      end
   end

   always_comb begin
      case (car_mode_out)
         CAR_START: carrier_in = cfg_ff.carrier_start_freq;
         CAR_END:   carrier_in = cfg_ff.carrier_end_freq;
         CAR_RAMP: begin
            if (cfg_ff.carrier_end_freq > cfg_ff.carrier_start_freq) begin
               carrier_in = cfg_ff.carrier_start_freq + car_quot;
            end else begin
               carrier_in = cfg_ff.carrier_start_freq - car_quot;
            end
         end
         default:   carrier_in = cfg_ff.carrier_start_freq;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[LATENCY-1]) begin
         rsp_data_ff <= {4'h0, duty_in[2], duty_in[1], duty_in[0], carrier_in};
      end
   end

   assign rsp_tvalid = valid_ff[LATENCY-1];
   assign rsp_tdata  = rsp_data_ff;

   `SPWM_ASSERT(a_full_stall, clock, reset, ((&valid_ff) && !rsp_tready) |-> !req_tready, "full pipeline with stalled output still takes words")
   `SPWM_ASSERT(a_empty_ready, clock, reset, (valid_ff == '0) |-> req_tready, "empty pipeline refuses words")
   `SPWM_ASSERT_NEXT(a_out_load, clock, reset, stage_en[LATENCY-1], rsp_tvalid == $past(valid_ff[LATENCY-2]), "output valid does not follow the last divider stage")

endmodule

`default_nettype wire

// ===== rtl/spwm_div.sv =====
`default_nettype none

module spwm_div #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 20,
   parameter int Q_W   = 20,
   parameter int SB_W  = 2
) (
   input  logic             clock,
   input  logic [Q_W-1:0]   stage_en,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [SB_W-1:0]  in_tag,
   output logic [Q_W-1:0]   quot,
   output logic [SB_W-1:0]  out_tag
);

   localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic [NUM_W-1:0] rem_ff  [Q_W];
   logic [DEN_W-1:0] den_ff  [Q_W];
   logic [Q_W-1:0]   quot_ff [Q_W];
   logic [SB_W-1:0]  tag_ff  [Q_W];

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar j = 0; j < Q_W; j++) begin : g_step
      logic [NUM_W-1:0] rem_src;
      logic [DEN_W-1:0] den_src;
      logic [Q_W-1:0]   quot_src;
      logic [SB_W-1:0]  tag_src;
      logic [CW-1:0]    trial;
      logic             fits;
      logic [NUM_W-1:0] rem_in;
      logic [Q_W-1:0]   quot_in;

      if (j == 0) begin : g_first
         assign rem_src  = in_num;
         assign den_src  = in_den;
         assign quot_src = '0;
         assign tag_src  = in_tag;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign den_src  = den_ff[j-1];
         assign quot_src = quot_ff[j-1];
         assign tag_src  = tag_ff[j-1];
      end

      assign trial   = CW'(den_src) << (Q_W - 1 - j);
      assign fits    = CW'(rem_src) >= trial;
      assign rem_in  = fits ? NUM_W'(CW'(rem_src) - trial) : rem_src;
      assign quot_in = quot_src | (Q_W'(fits) << (Q_W - 1 - j));

      always_ff @(posedge clock) begin
         if (stage_en[j]) begin
            rem_ff[j]  <= rem_in;
            den_ff[j]  <= den_src;
            quot_ff[j] <= quot_in;
            tag_ff[j]  <= tag_src;
         end
      end
   end

   assign quot    = quot_ff[Q_W-1];
   assign out_tag = tag_ff[Q_W-1];

endmodule

`default_nettype wire

// ===== rtl/spwm_carrier.sv =====
`default_nettype none

module spwm_carrier (
   input  logic                                  clock,
   input  logic [spwm_pkg::FRONT_STAGES-1:0]     stage_en,
   input  spwm_pkg::cfg_type                     cfg,
   input  logic signed [spwm_pkg::SPEED_W-1:0]   elec_speed,
   output logic [spwm_pkg::CAR_NUM_W-1:0]        div_num,
   output logic [spwm_pkg::FREQ_W-1:0]           div_den,
   output spwm_pkg::car_mode_type                mode
);

   import spwm_pkg::*;

   logic [SPEED_W-1:0]    speed_mag;
   logic [49:0]           speed_prod;
   logic [33:0]           f16_in;
   logic [33:0]           f16_ff;
   logic [FREQ_W-1:0]     carrier_diff;
   logic signed [20:0]    band_diff;
   logic                  bypass;
   logic signed [36:0]    num;
   logic [35:0]           den;
   logic [35:0]           num_in;
   logic [35:0]           num_ff;
   car_mode_type          mode_in;
   car_mode_type          mode2_ff;
   car_mode_type          mode3_ff;
   car_mode_type          mode4_ff;
   logic [55:0]           prod;
   logic [56:0]           sum;
   logic [CAR_NUM_W-1:0]  numer_in;
   logic [CAR_NUM_W-1:0]  numer3_ff;
   logic [CAR_NUM_W-1:0]  numer4_ff;

   // Fundamental frequency with 16 fraction bits.
   assign speed_mag  = elec_speed[SPEED_W-1] ? SPEED_W'(-elec_speed) : SPEED_W'(elec_speed);
   assign speed_prod = 50'(speed_mag) * 50'(INV_TWO_PI_Q32);
   assign f16_in     = 34'((speed_prod + 50'd32768) >> 16);

   assign carrier_diff = (cfg.carrier_start_freq > cfg.carrier_end_freq)
                       ? cfg.carrier_start_freq - cfg.carrier_end_freq
                       : cfg.carrier_end_freq - cfg.carrier_start_freq;
   assign band_diff = $signed({1'b0, cfg.band_end_freq}) - $signed({1'b0, cfg.band_start_freq});
   assign bypass    = (carrier_diff <= 20'd1) || (band_diff <= 21'sd1);

   assign num    = $signed({3'b000, f16_ff}) - $signed({1'b0, cfg.band_start_freq, 16'h0000});
   assign den    = {band_diff[19:0], 16'h0000};
   assign num_in = num[35:0];

   always_comb begin
      if (bypass || num <= 37'sd0) begin
         mode_in = CAR_START;
      end else if (num[35:0] >= den) begin
         mode_in = CAR_END;
      end else begin
         mode_in = CAR_RAMP;
      end
   end

   // Rounded step numerator, already divided by the 2^16 of the band scale.
   assign prod     = 56'(carrier_diff) * 56'(num_ff);
   assign sum      = 57'(prod) + 57'({band_diff[19:0], 15'h0000});
   assign numer_in = sum[55:16];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         f16_ff <= f16_in;
      end
      if (stage_en[1]) begin
         num_ff   <= num_in;
         mode2_ff <= mode_in;
      end
      if (stage_en[2]) begin
         numer3_ff <= numer_in;
         mode3_ff  <= mode2_ff;
      end
      if (stage_en[3]) begin
         numer4_ff <= numer3_ff;
         mode4_ff  <= mode3_ff;
      end
   end

   assign div_num = numer4_ff;
   assign div_den = band_diff[19:0];
   assign mode    = mode4_ff;

endmodule

`default_nettype wire

// ===== rtl/spwm_duty.sv =====
`default_nettype none

module spwm_duty (
   input  logic                                clock,
   input  logic [spwm_pkg::FRONT_STAGES-1:0]   stage_en,
   input  logic [spwm_pkg::MOD_W-1:0]          max_mod_index,
   input  logic signed [spwm_pkg::VOLT_W-1:0]  volt_alpha,
   input  logic signed [spwm_pkg::VOLT_W-1:0]  volt_beta,
   input  logic [spwm_pkg::BUS_W-1:0]          bus_voltage,
   output logic [spwm_pkg::DUTY_NUM_W-1:0]     div_num [spwm_pkg::LANES],
   output logic [spwm_pkg::MAG_W-1:0]          div_den,
   output spwm_pkg::duty_tag_type              tag [spwm_pkg::LANES]
);

   import spwm_pkg::*;

   logic signed [33:0]    half_a;
   logic signed [33:0]    beta_term;
   logic signed [33:0]    phase_in  [LANES];
   logic signed [33:0]    phase_ff  [LANES];
   logic [30:0]           lim_in;
   logic [30:0]           lim_ff;
   logic [BUS_W-1:0]      bus1_ff;
   logic [MAG_W-1:0]      mag_in    [LANES];
   logic [MAG_W-1:0]      mag2_ff   [LANES];
   logic                  neg2_ff   [LANES];
   logic [MAG_W-1:0]      mx_in;
   logic [MAG_W-1:0]      mx2_ff;
   logic                  scale_in;
   logic                  scale2_ff;
   logic [BUS_W-1:0]      bus2_ff;
   logic [DUTY_NUM_W-1:0] num3_in   [LANES];
   logic [DUTY_NUM_W-1:0] num3_ff   [LANES];
   logic                  neg3_ff   [LANES];
   logic [MAG_W-1:0]      den3_in;
   logic [MAG_W-1:0]      den3_ff;
   logic                  low3_ff;
   logic [DUTY_NUM_W-1:0] num4_ff   [LANES];
   logic [MAG_W-1:0]      den4_ff;
   duty_tag_type          tag4_in   [LANES];
   duty_tag_type          tag4_ff   [LANES];

   // Amplitude-invariant inverse Clarke, 16 fraction bits.
   assign half_a      = 34'(volt_alpha) <<< 15;
   assign beta_term   = 34'(volt_beta) * 34'($signed({1'b0, HALF_SQRT3_Q16}));
   assign phase_in[0] = 34'(volt_alpha) <<< 16;
   assign phase_in[1] = beta_term - half_a;
   assign phase_in[2] = 34'sd0 - half_a - beta_term;
   assign lim_in      = (31'(bus_voltage) * 31'(max_mod_index)) << 1;

   for (genvar i = 0; i < LANES; i++) begin : g_mag
      assign mag_in[i] = phase_ff[i][33] ? 32'(-phase_ff[i]) : 32'(phase_ff[i]);
   end

   always_comb begin
      mx_in = mag_in[0];
      if (mag_in[1] > mx_in) begin
         mx_in = mag_in[1];
      end
      if (mag_in[2] > mx_in) begin
         mx_in = mag_in[2];
      end
   end

   assign scale_in = (mx_in > 32'(lim_ff)) && (mx_in > TINY_MAG);

   // When scaling, the bus voltage cancels out of the division exactly.
   for (genvar i = 0; i < LANES; i++) begin : g_num
      assign num3_in[i] = scale2_ff
                        ? ((DUTY_NUM_W'(mag2_ff[i]) * DUTY_NUM_W'(max_mod_index)) << 1)
                          + DUTY_NUM_W'(mx2_ff >> 1)
                        : DUTY_NUM_W'(mag2_ff[i]) + DUTY_NUM_W'(bus2_ff >> 1);
      assign tag4_in[i] = '{low_bus: low3_ff,
                            sat:     num3_ff[i] >= DUTY_NUM_W'({den3_ff, 15'h0000}),
                            neg:     neg3_ff[i]};
   end

   assign den3_in = scale2_ff ? mx2_ff : MAG_W'(bus2_ff);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         phase_ff <= phase_in;
         lim_ff   <= lim_in;
         bus1_ff  <= bus_voltage;
      end
      if (stage_en[1]) begin
         mag2_ff   <= mag_in;
         for (int i = 0; i < LANES; i++) begin
            neg2_ff[i] <= phase_ff[i][33];
         end
         mx2_ff    <= mx_in;
         scale2_ff <= scale_in;
         bus2_ff   <= bus1_ff;
      end
      if (stage_en[2]) begin
         num3_ff <= num3_in;
         neg3_ff <= neg2_ff;
         den3_ff <= den3_in;
         low3_ff <= bus2_ff <= BUS_MIN;
      end
      if (stage_en[3]) begin
         num4_ff <= num3_ff;
         den4_ff <= den3_ff;
         tag4_ff <= tag4_in;
      end
   end

   assign div_num = num4_ff;
   assign div_den = den4_ff;
   assign tag     = tag4_ff;

endmodule

`default_nettype wire
